// File: design/dqs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes, types and ring arithmetic for the deque with search.
// No dependencies.
package dqs_pkg;

    localparam int DEPTH    = 16;                 // ring entries, 2 to 64
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = IDX_W + 1;          // holds 0 to DEPTH
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_CLEAR      = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_DUMP_FWD   = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_DUMP_REV   = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_SEARCH_FWD = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_SEARCH_REV = FUNC_W'(4);
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = FUNC_W'(5);
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = FUNC_W'(6);
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = FUNC_W'(7);
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = FUNC_W'(8);
    localparam logic [FUNC_W-1:0] FN_COUNT      = FUNC_W'(9);

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } dqs_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CHECK
    } dqs_state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } dqs_mem_req_t;

    // (head + offset) mod DEPTH; both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] offs);
        logic [CNT_W-1:0] sum;
        sum = {1'b0, head} + {1'b0, offs};
        if (sum >= CNT_W'(DEPTH))
        begin
            sum = sum - CNT_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: design/dqs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command items in, result items out.
// Depends on dqs_pkg.
interface dqs_cmd_if import dqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface dqs_res_if import dqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
    logic                     last;

    modport source (output valid, status, data, position, count, last, input ready);
    modport sink   (input valid, status, data, position, count, last, output ready);
endinterface

// File: design/dqs_store.sv
`timescale 1ns / 1ps
// Element store: DEPTH x 32 memory, one write port, one registered read port.
// Depends on dqs_pkg.
module dqs_store import dqs_pkg::*;
(
    input  logic              clk,
    input  dqs_mem_req_t      mem_req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // read data held until the next read
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dqs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: ring pointers, element walk with a single compare, result register.
// Depends on dqs_pkg, dqs_if.sv.
module dqs_ctrl import dqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dqs_cmd_if.sink           cmd,
    dqs_res_if.source         res,
    output dqs_mem_req_t      mem_req,
    input  logic [DATA_W-1:0] rd_data
);

    dqs_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    dqs_status_t         status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                is_dump, is_search, fwd;
    logic                empty, full, at_last, match;
    logic [CNT_W-1:0]    rev_pos;
    logic [IDX_W-1:0]    walk_pos;

    assign out_free  = !out_valid_reg || res.ready;
    assign is_dump   = (func_reg == FN_DUMP_FWD) || (func_reg == FN_DUMP_REV);
    assign is_search = (func_reg == FN_SEARCH_FWD) || (func_reg == FN_SEARCH_REV);
    assign fwd       = (func_reg == FN_DUMP_FWD) || (func_reg == FN_SEARCH_FWD);
    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign at_last   = (({1'b0, idx_reg} + CNT_W'(1)) == cnt_reg);
    assign match     = (rd_data == value_reg);
    assign rev_pos   = cnt_reg - CNT_W'(1) - {1'b0, idx_reg};
    assign walk_pos  = fwd ? idx_reg : rev_pos[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((is_dump || is_search) && !empty)
                begin
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_dump)
                begin
                    if (out_free)
                    begin
                        state_next = at_last ? S_IDLE : S_READ;
                    end
                end
                else if (match || at_last)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd.ready      = (state_reg == S_IDLE);
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        func_next      = func_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        pos_next       = pos_reg;
        ocnt_next      = ocnt_reg;
        last_next      = last_reg;

        mem_req.we     = 1'b0;
        mem_req.waddr  = ring_add(head_reg, cnt_reg[IDX_W-1:0]);
        mem_req.wdata  = value_reg;
        mem_req.re     = (state_reg == S_READ);
        mem_req.raddr  = ring_add(head_reg, walk_pos);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = cmd.func;
                    value_next = cmd.value;
                end
            end
            S_EXEC:
            begin
                if ((is_dump || is_search) && !empty)
                begin
                    idx_next = '0;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    data_next      = '0;
                    pos_next       = '0;
                    last_next      = 1'b1;
                    ocnt_next      = cnt_reg;
                    priority if (func_reg == FN_CLEAR)
                    begin
                        head_next = '0;
                        cnt_next  = '0;
                        ocnt_next = '0;
                    end
                    else if (is_dump)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (is_search)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if ((func_reg == FN_PUSH_FRONT) || (func_reg == FN_PUSH_BACK))
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.we = 1'b1;
                            if (func_reg == FN_PUSH_FRONT)
                            begin
                                head_next = (head_reg == '0) ? IDX_W'(DEPTH - 1)
                                                             : head_reg - IDX_W'(1);
                                mem_req.waddr = head_next;
                            end
                            cnt_next  = cnt_reg + CNT_W'(1);
                            ocnt_next = cnt_next;
                        end
                    end
                    else if ((func_reg == FN_POP_FRONT) || (func_reg == FN_POP_BACK))
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            if (func_reg == FN_POP_FRONT)
                            begin
                                head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                            : head_reg + IDX_W'(1);
                            end
                            cnt_next  = cnt_reg - CNT_W'(1);
                            ocnt_next = cnt_next;
                        end
                    end
                    else
                    begin
                        status_next = ST_DONE;   // count and unused codes
                    end
                end
            end
            S_READ:
            begin
            end
            S_CHECK:
            begin
                if (is_dump)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_DONE;
                        data_next      = rd_data;
                        pos_next       = walk_pos;
                        last_next      = at_last;
                        ocnt_next      = cnt_reg;
                        idx_next       = idx_reg + IDX_W'(1);
                    end
                end
                else if (match || at_last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = match ? ST_DONE : ST_NOT_FOUND;
                        data_next      = '0;
                        pos_next       = match ? walk_pos : '0;
                        last_next      = 1'b1;
                        ocnt_next      = cnt_reg;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        ocnt_reg   <= ocnt_next;
        last_reg   <= last_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.status   = status_reg;
    assign res.data     = data_reg;
    assign res.position = POS_W'(pos_reg);
    assign res.count    = COUNT_W'(ocnt_reg);
    assign res.last     = last_reg;

endmodule

// File: design/double_ended_queue_with_search.sv
`timescale 1ns / 1ps
// Top level of the deque with linear search: sequencer plus element store.
// Depends on dqs_pkg, dqs_if.sv, dqs_store, dqs_ctrl.
//
//  channel | dir | fields                              | handshake
//  --------+-----+-------------------------------------+------------
//  cmd     | in  | func[3:0], value[31:0] signed       | valid/ready
//  res     | out | status, data, position, count, last | valid/ready
//
// Steps: clear, push, pop, count and unused codes pass through accept and
// execute. A dump or a search on a non-empty deque then walks the elements:
// each step is one read of the single registered store port, then a check.
// A search checks on the single 32-bit comparator; a dump passes data to res.
// cmd.ready is high only while idle; one item is worked at a time.
// Results sit in an output register; a stalled res holds the walk in place.
// Reset empties the deque (head and count to zero); store contents are not reset.
module double_ended_queue_with_search import dqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dqs_cmd_if.sink   cmd,
    dqs_res_if.source res
);

    dqs_mem_req_t      mem_req;
    logic [DATA_W-1:0] rd_data;

    // sequencer: ring pointers, walk counter, comparator, result register
    dqs_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // ring buffer storage
    dqs_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule
